// ===== src/rgbhsl_pkg.sv =====
package rgbhsl_pkg;

  localparam int FRACTION_BITS = 6;

  localparam int CHAN_W    = 8;
  localparam int HUE_W     = 15;
  localparam int PCT_W     = 13;
  localparam int HUE_NUM_W = 17;   // 360 * 255 fits

  // Widest dividend is the hue numerator scaled by 2^(FRACTION_BITS+1)
  localparam int DIVIDEND_W          = HUE_NUM_W + FRACTION_BITS + 1;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          =
    (DIVIDEND_W + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
  localparam int DIV_W               = DIV_STAGES * DIV_STEPS_PER_STAGE;
  localparam int DIVISOR_W           = 9;   // 2 * 255

  localparam int DIV_LANES = 2;
  localparam int LANE_HUE  = 0;
  localparam int LANE_SAT  = 1;

  // four front stages, the divider, the output register
  localparam int PIPE_LAT = 4 + DIV_STAGES + 1;

  localparam logic [DIV_W-1:0]     HUE_TOP = DIV_W'(360) << FRACTION_BITS;
  localparam logic [DIV_W-1:0]     PCT_TOP = DIV_W'(100) << FRACTION_BITS;

  // luminance = floor((sum * 10 * 2^F + 25) / 51), done as a reciprocal multiply;
  // the shift leaves the reciprocal error below one for every sum up to 510
  localparam int LUM_NUM_W   = 13 + FRACTION_BITS;
  localparam int LUM_SHIFT   = 18 + FRACTION_BITS;
  localparam int LUM_RECIP_W = LUM_SHIFT - 5;
  localparam int LUM_PROD_W  = LUM_NUM_W + LUM_RECIP_W;
  localparam logic [LUM_RECIP_W-1:0] LUM_RECIP =
    LUM_RECIP_W'((64'd1 << LUM_SHIFT) / 64'd51 + 64'd1);
  localparam logic [LUM_NUM_W-1:0]   LUM_SCALE = LUM_NUM_W'(10 << FRACTION_BITS);
  localparam logic [LUM_NUM_W-1:0]   LUM_BIAS  = LUM_NUM_W'(25);

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue_out;
    logic [PCT_W-1:0] saturation_out;
    logic [PCT_W-1:0] luminance_out;
  } hsl_t;

  typedef enum logic [1:0] {
    HUE_BASE_0,
    HUE_BASE_120,
    HUE_BASE_240,
    HUE_BASE_360
  } hue_base_t;

  typedef struct packed {
    logic [DIV_W-1:0]     num;
    logic [DIVISOR_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [DIV_W-1:0]     num;
    logic [DIVISOR_W-1:0] den;
    logic [DIVISOR_W-1:0] rem;
    logic [DIV_W-1:0]     quo;
  } div_lane_t;

  // One restoring division step: shift in the next dividend bit.
  function automatic div_lane_t div_step(div_lane_t x);
    div_lane_t            y;
    logic [DIVISOR_W:0]   t;
    logic                 ge;
    t  = {x.rem, x.num[DIV_W-1]};
    ge = (t >= {1'b0, x.den});
    y  = x;
    y.rem = ge ? DIVISOR_W'(t - {1'b0, x.den}) : t[DIVISOR_W-1:0];
    y.quo = {x.quo[DIV_W-2:0], ge};
    y.num = {x.num[DIV_W-2:0], 1'b0};
    return y;
  endfunction

endpackage

// ===== src/rgbhsl_div.sv =====
module rgbhsl_div (
  input  logic                                                  clk,
  input  logic                                                  rst_n,
  input  logic                                                  in_vld,
  input  logic                                                  in_side,
  input  rgbhsl_pkg::div_req_t [rgbhsl_pkg::DIV_LANES-1:0]      req,
  output logic                                                  out_vld,
  output logic                                                  out_side,
  output logic [rgbhsl_pkg::DIV_LANES-1:0][rgbhsl_pkg::DIV_W-1:0] quo
);
  import rgbhsl_pkg::*;

  div_lane_t             lane_r   [DIV_STAGES][DIV_LANES];
  div_lane_t             lane_nxt [DIV_STAGES][DIV_LANES];
  logic [DIV_STAGES-1:0] vld_r;
  logic [DIV_STAGES-1:0] side_r;

  always_comb begin
    div_lane_t cur;
    for (int l = 0; l < DIV_LANES; l++) begin
      cur = '{num: req[l].num, den: req[l].den, rem: '0, quo: '0};
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
        cur = div_step(cur);
      end
      lane_nxt[0][l] = cur;
    end
    for (int s = 1; s < DIV_STAGES; s++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        cur = lane_r[s-1][l];
        for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
          cur = div_step(cur);
        end
        lane_nxt[s][l] = cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      for (int l = 0; l < DIV_LANES; l++) begin
        lane_r[s][l] <= lane_nxt[s][l];
      end
    end
    side_r <= {side_r[DIV_STAGES-2:0], in_side};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STAGES-2:0], in_vld};
    end
  end

  assign out_vld  = vld_r[DIV_STAGES-1];
  assign out_side = side_r[DIV_STAGES-1];

  always_comb begin
    for (int l = 0; l < DIV_LANES; l++) begin
      quo[l] = lane_r[DIV_STAGES-1][l].quo;
    end
  end

endmodule

// ===== src/rgb_to_hsl_converter.sv =====
// RGB to HSL pixel converter. A pixel transfer happens on every clock edge where start is
// high; busy is always low, so one pixel per clock is accepted. Each pixel gives exactly one
// result, out_valid high for one cycle with out_hsl, in input order. Between transfer and
// result lies the two-lane restoring divider for hue and saturation, which retires two
// quotient bits per stage over a 24-bit dividend (12 stages), behind four stages of max/min,
// difference and scaling logic and followed by one output register; luminance comes from a
// reciprocal multiply and rides a delay line beside the divider. The receiver cannot stall,
// so out_hsl must be taken in the cycle it is shown.
// Hue is degrees * 64, saturation and luminance are percent * 64, all rounded to nearest.
module rgb_to_hsl_converter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rgbhsl_pkg::pixel_t in_pixel,
  output logic               out_valid,
  output rgbhsl_pkg::hsl_t   out_hsl
);
  import rgbhsl_pkg::*;

  logic take;

  // stage 1: max, min, hue sector
  logic               s1_vld_r;
  logic [CHAN_W-1:0]  s1_mx_r, s1_mx_nxt;
  logic [CHAN_W-1:0]  s1_mn_r, s1_mn_nxt;
  hue_base_t          s1_base_r, s1_base_nxt;
  logic [CHAN_W:0]    s1_delta_r, s1_delta_nxt;

  // stage 2: spread, sum, scaled offset
  logic               s2_vld_r;
  logic [CHAN_W-1:0]  s2_d_r;
  logic [CHAN_W:0]    s2_sum_r;
  hue_base_t          s2_base_r;
  logic signed [15:0] s2_d60_r, s2_d60_nxt;

  // stage 3: numerators and saturation denominator
  logic                 s3_vld_r;
  logic                 s3_gray_r;
  logic [CHAN_W-1:0]    s3_d_r;
  logic [HUE_NUM_W-1:0] s3_hue_num_r, s3_hue_num_nxt;
  logic [CHAN_W-1:0]    s3_sat_den_r, s3_sat_den_nxt;
  logic [14:0]          s3_d100_r;
  logic [LUM_NUM_W-1:0] s3_lum_num_r;
  logic [HUE_NUM_W-1:0] base_d;

  // stage 4: divider requests, luminance
  logic                            s4_vld_r;
  logic                            s4_gray_r;
  div_req_t [DIV_LANES-1:0]        s4_req_r, s4_req_nxt;
  logic [PCT_W-1:0]                s4_lum_r, s4_lum_nxt;
  logic [LUM_PROD_W-1:0]           lum_prod;

  // luminance held beside the divider stages
  logic [PCT_W-1:0]                lum_dly_r [DIV_STAGES];

  logic                            dv_vld;
  logic                            dv_gray;
  logic [DIV_LANES-1:0][DIV_W-1:0] dv_quo;

  logic                            out_valid_r;
  hsl_t                            out_hsl_r, out_hsl_nxt;
  logic [DIV_W-1:0]                hue_c, sat_c;

  assign busy = 1'b0;
  assign take = start && !busy;

  always_comb begin
    logic [CHAN_W-1:0] r, g, b;
    r = in_pixel.red_in;
    g = in_pixel.green_in;
    b = in_pixel.blue_in;
    priority if (r >= g && r >= b) begin
      s1_mx_nxt    = r;
      s1_delta_nxt = {1'b0, g} - {1'b0, b};
      s1_base_nxt  = (g < b) ? HUE_BASE_360 : HUE_BASE_0;
    end else if (g >= b) begin
      s1_mx_nxt    = g;
      s1_delta_nxt = {1'b0, b} - {1'b0, r};
      s1_base_nxt  = HUE_BASE_120;
    end else begin
      s1_mx_nxt    = b;
      s1_delta_nxt = {1'b0, r} - {1'b0, g};
      s1_base_nxt  = HUE_BASE_240;
    end
    if (r <= g && r <= b) begin
      s1_mn_nxt = r;
    end else begin
      s1_mn_nxt = (g <= b) ? g : b;
    end
  end

  assign s2_d60_nxt = $signed({{(16-CHAN_W-1){s1_delta_r[CHAN_W]}}, s1_delta_r}) * 16'sd60;

  always_comb begin
    unique case (s2_base_r)
      HUE_BASE_0:   base_d = '0;
      HUE_BASE_120: base_d = HUE_NUM_W'(s2_d_r) * HUE_NUM_W'(120);
      HUE_BASE_240: base_d = HUE_NUM_W'(s2_d_r) * HUE_NUM_W'(240);
      HUE_BASE_360: base_d = HUE_NUM_W'(s2_d_r) * HUE_NUM_W'(360);
      default:      base_d = '0;
    endcase
    // offset may be negative; the total never is
    s3_hue_num_nxt = base_d + {{(HUE_NUM_W-16){s2_d60_r[15]}}, s2_d60_r};
    if (s2_sum_r <= (CHAN_W+1)'(255)) begin
      s3_sat_den_nxt = s2_sum_r[CHAN_W-1:0];
    end else begin
      s3_sat_den_nxt = CHAN_W'((CHAN_W+1)'(510) - s2_sum_r);
    end
  end

  // round(n * 2^F / q) = floor((n * 2^(F+1) + q) / (2q))
  always_comb begin
    s4_req_nxt[LANE_HUE].num = (DIV_W'(s3_hue_num_r) << (FRACTION_BITS + 1))
                             + DIV_W'(s3_d_r);
    s4_req_nxt[LANE_HUE].den = DIVISOR_W'(s3_d_r) << 1;
    s4_req_nxt[LANE_SAT].num = (DIV_W'(s3_d100_r) << (FRACTION_BITS + 1))
                             + DIV_W'(s3_sat_den_r);
    s4_req_nxt[LANE_SAT].den = DIVISOR_W'(s3_sat_den_r) << 1;
    lum_prod   = LUM_PROD_W'(s3_lum_num_r) * LUM_PROD_W'(LUM_RECIP);
    s4_lum_nxt = lum_prod[LUM_SHIFT +: PCT_W];
  end

  always_ff @(posedge clk) begin
    s1_mx_r      <= s1_mx_nxt;
    s1_mn_r      <= s1_mn_nxt;
    s1_base_r    <= s1_base_nxt;
    s1_delta_r   <= s1_delta_nxt;

    s2_d_r       <= s1_mx_r - s1_mn_r;
    s2_sum_r     <= {1'b0, s1_mx_r} + {1'b0, s1_mn_r};
    s2_base_r    <= s1_base_r;
    s2_d60_r     <= s2_d60_nxt;

    s3_gray_r    <= (s2_d_r == '0);
    s3_d_r       <= s2_d_r;
    s3_hue_num_r <= s3_hue_num_nxt;
    s3_sat_den_r <= s3_sat_den_nxt;
    s3_d100_r    <= 15'(s2_d_r) * 15'd100;
    s3_lum_num_r <= LUM_NUM_W'(s2_sum_r) * LUM_SCALE + LUM_BIAS;

    s4_gray_r    <= s3_gray_r;
    s4_req_r     <= s4_req_nxt;
    s4_lum_r     <= s4_lum_nxt;

    lum_dly_r[0] <= s4_lum_r;
    for (int s = 1; s < DIV_STAGES; s++) begin
      lum_dly_r[s] <= lum_dly_r[s-1];
    end

    out_hsl_r    <= out_hsl_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      s3_vld_r    <= 1'b0;
      s4_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_vld_r    <= take;
      s2_vld_r    <= s1_vld_r;
      s3_vld_r    <= s2_vld_r;
      s4_vld_r    <= s3_vld_r;
      out_valid_r <= dv_vld;
    end
  end

  rgbhsl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (s4_vld_r),
    .in_side  (s4_gray_r),
    .req      (s4_req_r),
    .out_vld  (dv_vld),
    .out_side (dv_gray),
    .quo      (dv_quo)
  );

  always_comb begin
    hue_c = (dv_quo[LANE_HUE] > HUE_TOP) ? HUE_TOP : dv_quo[LANE_HUE];
    sat_c = (dv_quo[LANE_SAT] > PCT_TOP) ? PCT_TOP : dv_quo[LANE_SAT];
    if (dv_gray) begin
      hue_c = '0;
      sat_c = '0;
    end
    out_hsl_nxt.hue_out        = hue_c[HUE_W-1:0];
    out_hsl_nxt.saturation_out = sat_c[PCT_W-1:0];
    out_hsl_nxt.luminance_out  = lum_dly_r[DIV_STAGES-1];
  end

  assign out_valid = out_valid_r;
  assign out_hsl   = out_hsl_r;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> ##PIPE_LAT out_valid)
    else $error("transfer did not produce a result");

  a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
    !take |-> ##PIPE_LAT !out_valid)
    else $error("result without a transfer");

  a_gray_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_pixel.red_in == in_pixel.green_in
          && in_pixel.green_in == in_pixel.blue_in)
    |-> ##PIPE_LAT (out_hsl.hue_out == '0 && out_hsl.saturation_out == '0))
    else $error("gray pixel gave nonzero hue or saturation");

  a_red_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (take && in_pixel.red_in > in_pixel.green_in
          && in_pixel.green_in == in_pixel.blue_in)
    |-> ##PIPE_LAT (out_hsl.hue_out == '0))
    else $error("pure red tone gave nonzero hue");

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
  import rgbhsl_pkg::*;

  localparam int STALL_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 600;   // per idling phase

  // Expected HSL values, in transfer order, and the mismatch count.
  class hsl_scoreboard;
    hsl_t expected_hsl[$];
    int   fails;

    function automatic bit [63:0] round_div(bit [63:0] n, bit [63:0] dn);
      return ((n << FRACTION_BITS) * 2 + dn) / (2 * dn);
    endfunction

    function automatic bit [63:0] clamp(bit [63:0] v, bit [63:0] top);
      return (v > top) ? top : v;
    endfunction

    function automatic hsl_t to_hsl(pixel_t p);
      bit [63:0] r, g, b, mx, mn, d, sum, num, hue, sat, lum, one;
      hue_base_t base;
      hsl_t      res;
      r   = 64'(p.red_in);
      g   = 64'(p.green_in);
      b   = 64'(p.blue_in);
      one = 64'd1 << FRACTION_BITS;
      mx  = r;
      mn  = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d   = mx - mn;
      sum = mx + mn;
      hue = '0;
      sat = '0;
      if (d != 0) begin
        // ties go to red, then green
        if (mx == r) base = (g >= b) ? HUE_BASE_0 : HUE_BASE_360;
        else if (mx == g) base = HUE_BASE_120;
        else base = HUE_BASE_240;
        case (base)
          HUE_BASE_0:   num = 60 * (g - b);
          HUE_BASE_360: num = 360 * d - 60 * (b - g);
          HUE_BASE_120: num = (b >= r) ? 120 * d + 60 * (b - r) : 120 * d - 60 * (r - b);
          default:      num = (r >= g) ? 240 * d + 60 * (r - g) : 240 * d - 60 * (g - r);
        endcase
        hue = clamp(round_div(num, d), 360 * one);
        sat = (sum <= 255) ? round_div(100 * d, sum) : round_div(100 * d, 510 - sum);
        sat = clamp(sat, 100 * one);
      end
      lum = clamp(round_div(100 * sum, 510), 100 * one);
      res.hue_out        = hue[HUE_W-1:0];
      res.saturation_out = sat[PCT_W-1:0];
      res.luminance_out  = lum[PCT_W-1:0];
      return res;
    endfunction

    function void note_pixel(pixel_t p);
      expected_hsl.insert(expected_hsl.size(), to_hsl(p));
    endfunction

    function int pending();
      return expected_hsl.size();
    endfunction

    function void report_field(string name, int unsigned exp_v, int unsigned act_v);
      fails++;
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
    endfunction

    function void check_hsl(hsl_t got);
      hsl_t exp_hsl;
      if (expected_hsl.size() == 0) begin
        fails++;
        $display("%0t unexpected result: expected none, actual %0d/%0d/%0d", $time,
                 got.hue_out, got.saturation_out, got.luminance_out);
        return;
      end
      exp_hsl = expected_hsl.pop_front();
      if (got.hue_out !== exp_hsl.hue_out)
        report_field("hue", 32'(exp_hsl.hue_out), 32'(got.hue_out));
      if (got.saturation_out !== exp_hsl.saturation_out)
        report_field("saturation", 32'(exp_hsl.saturation_out), 32'(got.saturation_out));
      if (got.luminance_out !== exp_hsl.luminance_out)
        report_field("luminance", 32'(exp_hsl.luminance_out), 32'(got.luminance_out));
    endfunction
  endclass

  logic   clk;
  logic   rst_n    = 1'b0;
  logic   start    = 1'b0;
  pixel_t in_pixel = '0;
  logic   busy;
  logic   out_valid;
  hsl_t   out_hsl;

  hsl_scoreboard hsl_sb = new();
  int            idle_cycles;

  rgb_to_hsl_converter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_pixel (in_pixel),
    .out_valid(out_valid),
    .out_hsl  (out_hsl)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) hsl_sb.check_hsl(out_hsl);
  end

  // Watchdog: cycles without any transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("rgb_to_hsl_converter verification failed");
        $finish;
      end
    end
  end

  // Call it just after a rising clock; it returns once the pixel has been transferred.
  task automatic send_pixel(input pixel_t p, input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_pixel <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    hsl_sb.note_pixel(p);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (hsl_sb.pending() != 0) @(posedge clk);
  endtask

  function automatic pixel_t rand_pixel();
    logic [7:0] v, w;
    pixel_t     p;
    v = 8'($urandom_range(255));
    w = 8'($urandom_range(255));
    case ($urandom_range(9))
      0: p = '{v, v, v};
      1: p = '{$urandom_range(1) ? 8'hff : 8'h00, $urandom_range(1) ? 8'hff : 8'h00,
               $urandom_range(1) ? 8'hff : 8'h00};
      2: begin
        // two channels tied
        case ($urandom_range(2))
          0:       p = '{v, v, w};
          1:       p = '{v, w, v};
          default: p = '{w, v, v};
        endcase
      end
      3: begin
        // difference of at most two
        v = 8'($urandom_range(1, 254));
        p = '{8'(v + $urandom_range(2) - 1), 8'(v + $urandom_range(2) - 1),
              8'(v + $urandom_range(2) - 1)};
      end
      default: p = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(255))};
    endcase
    return p;
  endfunction

  pixel_t directed[$] = '{
    '{8'd0,   8'd0,   8'd0},     // black
    '{8'd255, 8'd255, 8'd255},   // white
    '{8'd128, 8'd128, 8'd128},   // mid gray
    '{8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd255, 8'd0},
    '{8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd0,   8'd1},     // red max, green below blue: near 360
    '{8'd255, 8'd1,   8'd0},
    '{8'd255, 8'd255, 8'd0},     // red/green tie
    '{8'd0,   8'd255, 8'd255},   // green/blue tie
    '{8'd255, 8'd0,   8'd255},   // red/blue tie
    '{8'd10,  8'd200, 8'd50},
    '{8'd60,  8'd200, 8'd10},
    '{8'd100, 8'd20,  8'd220},
    '{8'd20,  8'd100, 8'd220},
    '{8'd128, 8'd127, 8'd127},   // sum exactly 255
    '{8'd128, 8'd128, 8'd127},
    '{8'd129, 8'd128, 8'd128},   // luminance just above half
    '{8'd1,   8'd0,   8'd0},
    '{8'd255, 8'd254, 8'd254},
    '{8'd170, 8'd85,  8'd0},
    '{8'd85,  8'd170, 8'd255},
    '{8'd1,   8'd254, 8'd127}
  };

  initial begin
    int idle_pct[3] = '{21, 71, 0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_pixel(directed[i], 30);
    drain();

    foreach (idle_pct[ph]) begin
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
        send_pixel(rand_pixel(), idle_pct[ph]);
        if ($urandom_range(99) == 0) drain();
      end
      drain();
    end

    repeat (PIPE_LAT + 8) @(posedge clk);
    if (hsl_sb.fails == 0 && hsl_sb.pending() == 0)
      $display("rgb_to_hsl_converter verification clean");
    else
      $display("rgb_to_hsl_converter verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/rgbhsl_pkg.sv
src/rgbhsl_div.sv
src/rgb_to_hsl_converter.sv
verif/tb_top.sv
